/* sv/mstp_pkg.sv */
// Shared types and constants for the master/stack tile placer.
// Holds register indexes, sequencer states, divider handshake structs and helpers.
// No dependencies.
package mstp_pkg;

  localparam int MaxWindows = 64;
  localparam int CoordBits  = 16;
  localparam int IdxW       = $clog2(MaxWindows + 1);
  localparam int DivBits    = 32;
  localparam int DivCntW    = $clog2(DivBits + 1);

  localparam logic LayoutMonocle = 1'b1;

  localparam logic [13:0] AreaWidthRst      = 14'd1920;
  localparam logic [13:0] AreaHeightRst     = 14'd1080;
  localparam logic [7:0]  MasterCountRst    = 8'd1;
  localparam logic [15:0] MasterFractionRst = 16'd36045;

  typedef enum logic [3:0] {
    REG_AREA_WIDTH      = 4'd0,
    REG_AREA_HEIGHT     = 4'd1,
    REG_GAP_OUTER_HORIZ = 4'd2,
    REG_GAP_OUTER_VERT  = 4'd3,
    REG_GAP_INNER_HORIZ = 4'd4,
    REG_GAP_INNER_VERT  = 4'd5,
    REG_MASTER_COUNT    = 4'd6,
    REG_MASTER_FRACTION = 4'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_COLUMN,
    ST_GAPMUL,
    ST_NUM,
    ST_DIV,
    ST_BOUND1,
    ST_BOUND2,
    ST_BOUND3,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Cut to CoordBits, sign-extend from there, then cut to 16 bits.
  function automatic logic [15:0] coord_out(input logic [31:0] v);
    logic [31:0] ext;
    ext = 32'($signed(v[CoordBits-1:0]));
    return ext[15:0];
  endfunction

endpackage

/* sv/master_stack_tile_placer_unit.sv */
// Master/stack tile placer: top level with sequencer, config registers and output register.
// Depends on mstp_pkg and on mstp_div for the height division.
// A tile request's time from accept to result is dominated by the 32-step serial divider.
// A monocle request skips the divider; a zero-count request is dropped with no result.
// Requests are taken one at a time: win_stall holds until the result is loaded into the output register.
// Reset (synchronous, active high) loads register defaults and clears index and offsets.
module master_stack_tile_placer_unit
  import mstp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               win_valid,
  output logic               win_stall,
  input  logic               first_window,
  input  logic               layout_mode,
  input  logic [6:0]         window_count,
  input  logic [7:0]         border_width,
  input  logic               gaps_enabled,
  input  logic [6:0]         smart_gap_count,
  // result channel
  output logic               box_valid,
  input  logic               box_stall,
  output logic signed [15:0] box_x,
  output logic signed [15:0] box_y,
  output logic signed [15:0] box_width,
  output logic signed [15:0] box_height,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [13:0] area_width;
  logic [13:0] area_height;
  logic [7:0]  gap_outer_horiz;
  logic [7:0]  gap_outer_vert;
  logic [7:0]  gap_inner_horiz;
  logic [7:0]  gap_inner_vert;
  logic [7:0]  master_count;
  logic [15:0] master_fraction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width      <= AreaWidthRst;
      area_height     <= AreaHeightRst;
      gap_outer_horiz <= '0;
      gap_outer_vert  <= '0;
      gap_inner_horiz <= '0;
      gap_inner_vert  <= '0;
      master_count    <= MasterCountRst;
      master_fraction <= MasterFractionRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AREA_WIDTH:      area_width      <= cfg_data[13:0];
        REG_AREA_HEIGHT:     area_height     <= cfg_data[13:0];
        REG_GAP_OUTER_HORIZ: gap_outer_horiz <= cfg_data[7:0];
        REG_GAP_OUTER_VERT:  gap_outer_vert  <= cfg_data[7:0];
        REG_GAP_INNER_HORIZ: gap_inner_horiz <= cfg_data[7:0];
        REG_GAP_INNER_VERT:  gap_inner_vert  <= cfg_data[7:0];
        REG_MASTER_COUNT:    master_count    <= cfg_data[7:0];
        REG_MASTER_FRACTION: master_fraction <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request capture. The count is clipped to MaxWindows; smart gaps compare
  // against the clipped count.
  // ---------------------------------------------------------------------------
  state_t      state;
  state_t      state_next;
  logic        win_accept;
  logic [6:0]  n_clip;
  logic        e_in;

  assign win_accept = win_valid && !win_stall;
  assign n_clip     = (32'(window_count) > MaxWindows) ? 7'(MaxWindows) : window_count;
  assign e_in       = gaps_enabled && (smart_gap_count != n_clip);

  logic       first_q;
  logic       kind_q;
  logic [6:0] n_q;
  logic [7:0] bw_q;
  logic       e_q;

  always_ff @(posedge clk) begin
    if (win_accept) begin
      first_q <= first_window;
      kind_q  <= layout_mode;
      n_q     <= n_clip;
      bw_q    <= border_width;
      e_q     <= e_in;
    end
  end

  // gaps after the enable
  logic [7:0] goh_e;
  logic [7:0] gov_e;
  logic [7:0] gih_e;
  logic [7:0] giv_e;

  assign goh_e = e_q ? gap_outer_horiz : 8'd0;
  assign gov_e = e_q ? gap_outer_vert  : 8'd0;
  assign gih_e = e_q ? gap_inner_horiz : 8'd0;
  assign giv_e = e_q ? gap_inner_vert  : 8'd0;

  // ---------------------------------------------------------------------------
  // Pass state and working registers
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0] window_index;
  logic [31:0]     master_y_offset;
  logic [31:0]     stack_y_offset;

  logic [30:0] prod;       // (W + inner vertical gap) * fraction
  logic        is_master;
  logic [31:0] r;          // windows left in the column, wraps
  logic [31:0] mw;         // master column width
  logic [31:0] gmul;       // inner gap times (r - 1)
  logic [31:0] base;       // H - y - outer gap
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] w;
  logic [31:0] h;

  // column choice and remaining count
  logic        master_c;
  logic [7:0]  min_nm;
  logic [31:0] r_c;
  logic [31:0] mw_c;
  logic [31:0] mw_frac;

  assign master_c = 32'(window_index) < 32'(master_count);
  assign min_nm   = (8'(n_q) < master_count) ? 8'(n_q) : master_count;
  assign r_c      = master_c ? (32'(min_nm) - 32'(window_index))
                             : (32'(n_q) - 32'(window_index));
  assign mw_frac  = (32'(prod) + 32'd32768) >> 16;

  always_comb begin
    if (8'(n_q) > master_count) begin
      mw_c = (master_count != 8'd0) ? mw_frac : 32'd0;
    end else begin
      mw_c = 32'(area_width) - (32'(gov_e) << 1) + 32'(giv_e);
    end
  end

  // gap multiply: narrow gap by the 32-bit remaining count minus one
  logic [31:0] rm1;
  logic [39:0] gmul_full;

  assign rm1       = r - 32'd1;
  assign gmul_full = 40'(gih_e) * 40'(rm1);

  // numerator and divider hookup
  logic [31:0] num;
  div_ctl_t    div_ctl;
  div_sts_t    div_sts;
  logic [31:0] div_quo;

  assign num = base - gmul;

  mstp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (num),
    .divisor  (r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // bounds helpers
  logic [31:0] least;
  logic [31:0] xw_sum;
  logic [31:0] yh_sum;

  assign least  = 32'd1 + (32'(bw_q) << 1);
  assign xw_sum = x + w;
  assign yh_sum = y + h;

  logic box_free;
  assign box_free = !box_valid || !box_stall;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (win_accept && (n_clip != 7'd0)) state_next = ST_SETUP;
      ST_SETUP:  state_next = (kind_q == LayoutMonocle) ? ST_BOUND1 : ST_COLUMN;
      ST_COLUMN: state_next = ST_GAPMUL;
      ST_GAPMUL: state_next = ST_NUM;
      ST_NUM:    state_next = (r != 32'd0) ? ST_DIV : ST_BOUND1;
      ST_DIV:    if (div_sts.done) state_next = ST_BOUND1;
      ST_BOUND1: state_next = ST_BOUND2;
      ST_BOUND2: state_next = ST_BOUND3;
      ST_BOUND3: state_next = ST_FINISH;
      ST_FINISH: if (box_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    win_stall     = (state != ST_IDLE);
    div_ctl.start = (state == ST_NUM) && (r != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Pass state: restart on a first window, advance the column offset (tile mode only)
  // and the index once the box is final.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_index    <= '0;
      master_y_offset <= '0;
      stack_y_offset  <= '0;
    end else begin
      if (state == ST_SETUP && first_q) begin
        window_index    <= '0;
        master_y_offset <= 32'(goh_e);
        stack_y_offset  <= 32'(goh_e);
      end
      if (state == ST_BOUND3) begin
        if (kind_q != LayoutMonocle) begin
          if (is_master) begin
            master_y_offset <= master_y_offset + h + 32'(gih_e);
          end else begin
            stack_y_offset <= stack_y_offset + h + 32'(gih_e);
          end
        end
        // hold at MaxWindows once the pass runs past its count
        if (32'(window_index) < MaxWindows) begin
          window_index <= window_index + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: one step per state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_SETUP: begin
        prod <= (31'(area_width) + 31'(giv_e)) * 31'(master_fraction);
        x    <= '0;
        y    <= '0;
        w    <= 32'(area_width);
        h    <= 32'(area_height);
      end
      ST_COLUMN: begin
        is_master <= master_c;
        r         <= r_c;
        mw        <= mw_c;
        y         <= master_c ? master_y_offset : stack_y_offset;
      end
      ST_GAPMUL: begin
        gmul <= gmul_full[31:0];
        base <= 32'(area_height) - y - 32'(goh_e);
        if (is_master) begin
          x <= 32'(gov_e);
          w <= mw - 32'(giv_e);
        end else begin
          x <= mw + 32'(gov_e);
          w <= 32'(area_width) - mw - (32'(gov_e) << 1);
        end
      end
      ST_NUM: begin
        // a zero count sets the height to zero
        if (r == 32'd0) h <= '0;
      end
      ST_DIV: begin
        if (div_sts.done) h <= div_quo;
      end
      ST_BOUND1: begin
        if ($signed(w) < $signed(least)) w <= least;
        if ($signed(h) < $signed(least)) h <= least;
      end
      ST_BOUND2: begin
        if ($signed(x) >= $signed(32'(area_width)))  x <= 32'(area_width) - w;
        if ($signed(y) >= $signed(32'(area_height))) y <= 32'(area_height) - h;
      end
      ST_BOUND3: begin
        if ($signed(xw_sum) <= 0) x <= '0;
        if ($signed(yh_sum) <= 0) y <= '0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: load when free, drop the valid once taken
  // ---------------------------------------------------------------------------
  logic box_load;
  assign box_load = (state == ST_FINISH) && box_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (box_load) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (box_load) begin
      box_x      <= coord_out(x);
      box_y      <= coord_out(y);
      box_width  <= coord_out(w);
      box_height <= coord_out(h);
    end
  end

`ifndef ASSERT_OFF
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    32'(window_index) <= MaxWindows)
    else $error("window index past its limit");

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (win_accept && window_count == 7'd0) |=> (state == ST_IDLE) && $stable(window_index))
    else $error("zero-count request changed state");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(box_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish step");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == ST_DIV)
    else $error("divider finished while not awaited");

  a_div_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_sts.busy || div_sts.done))
    else $error("waiting on an idle divider");
`endif

endmodule

/* sv/mstp_div.sv */
// Iterative unsigned divider for the tile placer, one quotient bit per cycle.
// Depends on mstp_pkg for widths and the handshake structs.
module mstp_div
  import mstp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  div_ctl_t           ctl,
  input  logic [DivBits-1:0] dividend,
  input  logic [DivBits-1:0] divisor,
  output div_sts_t           sts,
  output logic [DivBits-1:0] quotient
);

  logic [DivBits-1:0] rem;
  logic [DivBits-1:0] quo;
  logic [DivBits-1:0] dvs;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DivBits:0]   shifted;
  logic [DivBits:0]   diff;

  assign shifted = {rem, quo[DivBits-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= DivCntW'(DivBits);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      // take the trial subtract when it does not borrow
      if (!diff[DivBits]) begin
        rem <= diff[DivBits-1:0];
        quo <= {quo[DivBits-2:0], 1'b1};
      end else begin
        rem <= shifted[DivBits-1:0];
        quo <= {quo[DivBits-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;

endmodule
